// ===== rtl/rnp_pkg.sv =====
// Shared types, widths and constants of the ring-tone note parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rnp_pkg;

    // Duration digits saturate here; accumulator width follows from it.
    localparam int DURATION_LIMIT = 1023;
    localparam int DUR_W          = $clog2(DURATION_LIMIT + 1);

    // Field and register widths.
    localparam int CHAR_W      = 8;
    localparam int CFG_DUR_W   = 10;
    localparam int OCT_W       = 4;
    localparam int BPM_W       = 10;
    localparam int HZ_W        = 14;
    localparam int MS_W        = 19;
    localparam int LETTER_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int NOTE_DUR_W  = (DUR_W > CFG_DUR_W) ? DUR_W : CFG_DUR_W;

    // Serial divider: 18-bit dividend, two quotient bits per cycle.
    localparam int DVD_W      = 18;
    localparam int DVS_W      = (NOTE_DUR_W > BPM_W) ? NOTE_DUR_W : BPM_W;
    localparam int DIV_STEPS  = DVD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Whole note is this many milliseconds divided by the tempo.
    localparam logic [DVD_W-1:0] WHOLE_MS     = DVD_W'(240000);
    localparam logic [BPM_W-1:0] BPM_FALLBACK = BPM_W'(63);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OCTAVE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_MINUTE = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_DUR_W-1:0] RST_DEFAULT_DURATION = CFG_DUR_W'(4);
    localparam logic [OCT_W-1:0]     RST_DEFAULT_OCTAVE   = OCT_W'(6);
    localparam logic [BPM_W-1:0]     RST_BEATS_PER_MINUTE = BPM_W'(63);
    localparam logic [OCT_W-1:0]     OCT_MAX              = OCT_W'(9);
    localparam logic [OCT_W-1:0]     OCT_BASE             = OCT_W'(4);

    // Letter codes; zero stands for a rest or an unknown letter.
    localparam logic [LETTER_W-1:0] LT_REST = 3'd0;
    localparam logic [LETTER_W-1:0] LT_C    = 3'd1;
    localparam logic [LETTER_W-1:0] LT_D    = 3'd2;
    localparam logic [LETTER_W-1:0] LT_E    = 3'd3;
    localparam logic [LETTER_W-1:0] LT_F    = 3'd4;
    localparam logic [LETTER_W-1:0] LT_G    = 3'd5;
    localparam logic [LETTER_W-1:0] LT_A    = 3'd6;
    localparam logic [LETTER_W-1:0] LT_B    = 3'd7;

    // One note as handed from the parser to the timing sequencer.
    typedef struct packed {
        logic [LETTER_W-1:0]   letter;
        logic                  sharp;
        logic                  dotted;
        logic [OCT_W-1:0]      oct;
        logic [NOTE_DUR_W-1:0] dur;
    } t_note;

endpackage

`default_nettype wire

// ===== rtl/rtttl_note_parser.sv =====
// Ring-tone note parser top level: registers, parser, divider sequencer, output.
// A character that ends no note leaves the input ready. A note is shown after
// its character's transfer, two divider passes (tempo, then duration) and the
// length and output register loads, a second one after two more passes and loads;
// input is ready again once the last note is loaded, later while the output stalls.
// Reset (synchronous, active low) sets the registers to 4, 6, 63 and idles the parser.
`default_nettype none

module rtttl_note_parser (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // Configuration write channel
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [rnp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [rnp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Character stream
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [7:0]                     s_axis_tdata,  // [7:0] char_code
    input  wire                           s_axis_tlast,  // end_of_text
    // Note stream
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [55:0]                   m_axis_tdata,  // [13:0] tone_hz,
                                                         // [32:14] sound_ms,
                                                         // [51:33] silence_ms
    output logic                          m_axis_tlast   // last_in_run
);
    import rnp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WHOLE, S_LEN, S_OUT} t_seq;

    logic [CFG_DUR_W-1:0] r_def_dur;
    logic [OCT_W-1:0]     r_def_oct;
    logic [BPM_W-1:0]     r_bpm;

    t_seq             r_state;
    t_note            r_cur, r_next;
    logic             r_more;
    logic [MS_W-1:0]  r_len;
    logic             r_out_valid;
    logic             r_out_last;
    logic [HZ_W-1:0]  r_out_hz;
    logic [MS_W-1:0]  r_out_snd;
    logic [MS_W-1:0]  r_out_sil;

    logic             in_xfer;
    logic             out_free;
    logic [1:0]       emit_cnt;
    t_note            note0, note1;
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dividend, div_quo;
    logic [DVS_W-1:0] div_divisor;
    logic [BPM_W-1:0] bpm_eff;
    logic [MS_W-1:0]  len_calc;
    logic [8:0]       base_hz;
    logic [HZ_W-1:0]  hz_calc;
    logic [MS_W-1:0]  sil_calc, snd_calc;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_dur <= RST_DEFAULT_DURATION;
            r_def_oct <= RST_DEFAULT_OCTAVE;
            r_bpm     <= RST_BEATS_PER_MINUTE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEFAULT_DURATION: r_def_dur <= i_cfg_data[CFG_DUR_W-1:0];
                CFG_DEFAULT_OCTAVE:   r_def_oct <= i_cfg_data[OCT_W-1:0];
                CFG_BEATS_PER_MINUTE: r_bpm     <= i_cfg_data[BPM_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    rnp_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_xfer),
        .i_char             (s_axis_tdata),
        .i_eot              (s_axis_tlast),
        .i_default_duration (r_def_dur),
        .i_default_octave   (r_def_oct),
        .o_emit_cnt         (emit_cnt),
        .o_note0            (note0),
        .o_note1            (note1)
    );

    // Divider operands: tempo pass first, then the duration pass.
    assign bpm_eff      = (r_bpm != '0) ? r_bpm : BPM_FALLBACK;
    assign div_start    = (r_state == S_IDLE && in_xfer && emit_cnt != 2'd0)
                       || (r_state == S_WHOLE && div_done)
                       || (r_state == S_OUT && out_free && r_more);
    assign div_dividend = (r_state == S_WHOLE) ? div_quo : WHOLE_MS;
    assign div_divisor  = (r_state == S_WHOLE) ? DVS_W'(r_cur.dur) : DVS_W'(bpm_eff);

    rnp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Dotted length is len + len/2, which equals 3*len/2 truncated.
    assign len_calc = r_cur.dotted ? (MS_W'(div_quo) + MS_W'(div_quo >> 1))
                                   : MS_W'(div_quo);

    // Octave-4 pitch of the letter, then the octave shift.
    always_comb begin
        case (r_cur.letter)
            LT_C:    base_hz = r_cur.sharp ? 9'd277 : 9'd262;
            LT_D:    base_hz = r_cur.sharp ? 9'd311 : 9'd294;
            LT_E:    base_hz = 9'd330;
            LT_F:    base_hz = r_cur.sharp ? 9'd370 : 9'd349;
            LT_G:    base_hz = r_cur.sharp ? 9'd415 : 9'd392;
            LT_A:    base_hz = r_cur.sharp ? 9'd466 : 9'd440;
            LT_B:    base_hz = 9'd494;
            default: base_hz = 9'd0;
        endcase
        if (r_cur.oct >= OCT_BASE)
            hz_calc = HZ_W'(base_hz) << (r_cur.oct - OCT_BASE);
        else
            hz_calc = HZ_W'(base_hz) >> (OCT_BASE - r_cur.oct);
    end

    // Sound and silence split; a rest is silence only.
    always_comb begin
        if (hz_calc == '0) begin
            sil_calc = r_len;
            snd_calc = '0;
        end else begin
            sil_calc = r_len >> 4;
            snd_calc = r_len - (r_len >> 4);
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && emit_cnt != 2'd0) begin
                        r_cur   <= note0;
                        r_next  <= note1;
                        r_more  <= (emit_cnt == 2'd2);
                        r_state <= S_WHOLE;
                    end
                end
                S_WHOLE: begin
                    if (div_done)
                        r_state <= S_LEN;
                end
                S_LEN: begin
                    if (div_done) begin
                        r_len   <= len_calc;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hz    <= hz_calc;
                        r_out_snd   <= snd_calc;
                        r_out_sil   <= sil_calc;
                        r_out_last  <= !r_more;
                        if (r_more) begin
                            r_cur   <= r_next;
                            r_more  <= 1'b0;
                            r_state <= S_WHOLE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_sil, r_out_snd, r_out_hz};
    assign m_axis_tlast  = r_out_last;

    // No second note may be pending while new characters are taken.
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_more) else $error("input ready with a note pending");

    // Divider results arrive only while the sequencer waits for them.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WHOLE || r_state == S_LEN))
        else $error("divider result outside a waiting state");

    // Loading the output register always presents a note.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> m_axis_tvalid)
        else $error("finished note not presented");

endmodule

`default_nettype wire

// ===== rtl/rnp_divider.sv =====
// Shared restoring divider, two quotient bits per cycle.
// Depends on rnp_pkg for the dividend and divisor widths.
`default_nettype none

module rnp_divider (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [rnp_pkg::DVD_W-1:0] i_dividend,
    input  wire [rnp_pkg::DVS_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [rnp_pkg::DVD_W-1:0] o_quotient
);
    import rnp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_acc;

    logic [DVS_W:0]   t1, t2;
    logic             q1, q2;
    logic [DVS_W-1:0] rem1, n_rem;
    logic [DVD_W-1:0] n_acc;

    // Two dependent trial subtractions per cycle.
    always_comb begin
        t1    = {r_rem, r_acc[DVD_W-1]};
        q1    = (t1 >= {1'b0, r_dvs});
        rem1  = q1 ? DVS_W'(t1 - {1'b0, r_dvs}) : DVS_W'(t1);
        t2    = {rem1, r_acc[DVD_W-2]};
        q2    = (t2 >= {1'b0, r_dvs});
        n_rem = q2 ? DVS_W'(t2 - {1'b0, r_dvs}) : DVS_W'(t2);
        n_acc = {r_acc[DVD_W-3:0], q1, q2};
    end

    // Dividend bits shift out of the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_acc <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;

    // A new division is never started over one in progress.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");

    // The last step is followed by the done pulse.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> r_done)
        else $error("divider missed its done pulse");

    // Done and busy never overlap.
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");

endmodule

`default_nettype wire

// ===== rtl/rnp_parser.sv =====
// Character parser of the note section: holds the note being built and
// reports up to two finished notes per character. Depends on rnp_pkg.
`default_nettype none

module rnp_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire [rnp_pkg::CHAR_W-1:0]    i_char,
    input  wire                          i_eot,
    input  wire [rnp_pkg::CFG_DUR_W-1:0] i_default_duration,
    input  wire [rnp_pkg::OCT_W-1:0]     i_default_octave,
    output logic [1:0]                   o_emit_cnt,
    output rnp_pkg::t_note               o_note0,
    output rnp_pkg::t_note               o_note1
);
    import rnp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DIGITS, PH_PRE, PH_LETTER, PH_SHARP, PH_DOT, PH_OCT, PH_TRAIL
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [DUR_W-1:0]    accum;
        logic                given;
        logic [LETTER_W-1:0] letter;
        logic                sharp;
        logic                dotted;
        logic [OCT_W-1:0]    oct;
    } t_pstate;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;
    localparam int               ACC_W    = DUR_W + 4;

    function automatic logic [OCT_W-1:0] clamp_oct(input logic [OCT_W-1:0] o);
        return (o > OCT_MAX) ? OCT_MAX : o;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
        case (c)
            8'h63:   return LT_C;
            8'h64:   return LT_D;
            8'h65:   return LT_E;
            8'h66:   return LT_F;
            8'h67:   return LT_G;
            8'h61:   return LT_A;
            8'h62:   return LT_B;
            default: return LT_REST;
        endcase
    endfunction

    function automatic t_pstate clear_st(input logic [OCT_W-1:0] def_oct);
        t_pstate s;
        s       = '0;
        s.phase = PH_IDLE;
        s.oct   = clamp_oct(def_oct);
        return s;
    endfunction

    function automatic t_pstate take_letter(input t_pstate s_in,
                                            input logic [CHAR_W-1:0] c,
                                            input logic [OCT_W-1:0] def_oct);
        t_pstate s;
        s        = s_in;
        s.letter = letter_code(c);
        s.sharp  = 1'b0;
        s.dotted = 1'b0;
        s.oct    = clamp_oct(def_oct);
        s.phase  = PH_LETTER;
        return s;
    endfunction

    function automatic t_pstate start_char(input t_pstate s_in,
                                           input logic [CHAR_W-1:0] c,
                                           input logic ws, input logic dig,
                                           input logic [OCT_W-1:0] def_oct);
        t_pstate          s;
        logic [ACC_W-1:0] v;
        s = s_in;
        v = '0;
        if (dig) begin
            v       = ACC_W'(s.accum) * ACC_W'(10) + ACC_W'(c[3:0]);
            s.accum = (v > ACC_W'(DURATION_LIMIT)) ? DUR_W'(DURATION_LIMIT)
                                                   : DUR_W'(v);
            s.given = 1'b1;
            s.phase = PH_DIGITS;
        end else if (!ws) begin
            s = take_letter(s, c, def_oct);
        end
        return s;
    endfunction

    // Snapshot of a finished note; the duration is resolved here.
    function automatic t_note mk_note(input t_pstate s,
                                      input logic [CFG_DUR_W-1:0] def_dur);
        t_note n;
        n.letter = s.letter;
        n.sharp  = s.sharp;
        n.dotted = s.dotted;
        n.oct    = clamp_oct(s.oct);
        if (s.given && s.accum != '0)
            n.dur = NOTE_DUR_W'(s.accum);
        else if (def_dur != '0)
            n.dur = NOTE_DUR_W'(def_dur);
        else
            n.dur = NOTE_DUR_W'(1);
        return n;
    endfunction

    t_pstate           r_st;
    t_pstate           n_st;
    logic [CHAR_W-1:0] c;
    logic              ws, dig;
    logic              f_emit, e_emit;
    t_note             f_note, e_note;

    // Next parser state and the notes finished by this character.
    always_comb begin
        c = i_char;
        if (c inside {[CH_UP_A:CH_UP_Z]})
            c = c + CASE_OFS;
        ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        dig    = c inside {[CH_ZERO:CH_NINE]};
        n_st   = r_st;
        f_emit = 1'b0;
        e_emit = 1'b0;
        f_note = '0;
        e_note = '0;

        case (r_st.phase)
            PH_IDLE: begin
                n_st = start_char(n_st, c, ws, dig, i_default_octave);
            end
            PH_DIGITS: begin
                if (ws)
                    n_st.phase = PH_PRE;
                else if (dig)
                    n_st = start_char(n_st, c, ws, dig, i_default_octave);
                else
                    n_st = take_letter(n_st, c, i_default_octave);
            end
            PH_PRE: begin
                if (!ws)
                    n_st = take_letter(n_st, c, i_default_octave);
            end
            default: begin
                if (c == CH_COMMA) begin
                    f_emit = 1'b1;
                    f_note = mk_note(n_st, i_default_duration);
                    n_st   = clear_st(i_default_octave);
                end else if (ws) begin
                    n_st.phase = PH_TRAIL;
                end else if (c == CH_SHARP && r_st.phase == PH_LETTER) begin
                    n_st.sharp = 1'b1;
                    n_st.phase = PH_SHARP;
                end else if (c == CH_DOT && r_st.phase != PH_TRAIL) begin
                    n_st.dotted = 1'b1;
                    n_st.phase  = (r_st.phase inside {PH_LETTER, PH_SHARP}) ? PH_DOT
                                                                             : PH_TRAIL;
                end else if (dig && !(r_st.phase inside {PH_OCT, PH_TRAIL})) begin
                    n_st.oct   = c[OCT_W-1:0];
                    n_st.phase = PH_OCT;
                end else begin
                    f_emit = 1'b1;
                    f_note = mk_note(n_st, i_default_duration);
                    n_st   = clear_st(i_default_octave);
                    n_st   = start_char(n_st, c, ws, dig, i_default_octave);
                end
            end
        endcase

        // End of text flushes a note that has its letter and restarts.
        if (i_eot) begin
            if (n_st.phase inside {PH_LETTER, PH_SHARP, PH_DOT, PH_OCT, PH_TRAIL}) begin
                e_emit = 1'b1;
                e_note = mk_note(n_st, i_default_duration);
            end
            n_st = clear_st(i_default_octave);
        end
    end

    always_comb begin
        if (f_emit) begin
            o_note0    = f_note;
            o_note1    = e_note;
            o_emit_cnt = e_emit ? 2'd2 : 2'd1;
        end else begin
            o_note0    = e_note;
            o_note1    = f_note;
            o_emit_cnt = e_emit ? 2'd1 : 2'd0;
        end
    end

    // Parser state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_st <= clear_st(RST_DEFAULT_OCTAVE);
        else if (i_accept)
            r_st <= n_st;
    end

endmodule

`default_nettype wire
